FILE: hdl/mlpfi_pkg.sv
// Shared constants, types and codes of the fixed-point MLP inference unit.
package mlpfi_pkg;

  // Network limits and store size
  localparam int MAX_INPUTS   = 64;
  localparam int MAX_LAYERS   = 4;
  localparam int MAX_NODES    = 64;
  localparam int MAX_OUTPUTS  = 16;
  localparam int WEIGHT_DEPTH = 32768;

  // Leaky slope, about 0.1 in Q0.16
  localparam int LEAK_MUL = 6554;

  // Field and register widths
  localparam int DATA_W   = 16;
  localparam int WADDR_W  = $clog2(WEIGHT_DEPTH);
  localparam int OIDX_W   = 4;
  localparam int IC_W     = 7;
  localparam int HL_W     = 3;
  localparam int NC_W     = 7;
  localparam int OC_W     = 5;
  localparam int CFG_DW   = 7;
  localparam int CFG_IW   = 2;

  // Derived internal widths
  localparam int MAX_SRC  = (MAX_INPUTS > MAX_NODES) ? MAX_INPUTS : MAX_NODES;
  localparam int STEP_W   = $clog2(MAX_SRC + 1);
  localparam int CNT_W    = $clog2(MAX_INPUTS + 1);
  localparam int IN_AW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int NODE_AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LAYER_W  = $clog2(MAX_LAYERS + 1);
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ACC_W    = PROD_W + $clog2(MAX_SRC + 1) + 1;

  // Item modes
  localparam logic MODE_WEIGHT = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Register indexes
  localparam logic [CFG_IW-1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HIDDEN_COUNT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_NODE_COUNT   = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_OUTPUT_COUNT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_LEAK,
    ST_STORE
  } state_e;

endpackage

FILE: hdl/mlpfi_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module mlpfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/mlp_forward_inference_unit.sv
// Fixed-point (Q8.8) MLP inference with leaky ReLU on one shared multiplier.
// Throughput: one weight or non-final sample transfer per cycle; busy during an inference.
// Each node issues one product per cycle over its sources and then its bias, drains the
// MAC pipe, applies the leaky slope and stores; a stalled result holds up the output layer.
// Reset: control, counters and config (all 1) clear; weight/layer stores are not cleared.
module mlp_forward_inference_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // item channel
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    mode_i,
  input  logic [mlpfi_pkg::WADDR_W-1:0]           weight_index_i,
  input  logic signed [mlpfi_pkg::DATA_W-1:0]     data_value_i,
  // result channel
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [mlpfi_pkg::DATA_W-1:0]     out_value_o,
  output logic [mlpfi_pkg::OIDX_W-1:0]            out_index_o,
  output logic                                    last_o,
  // configuration writes
  input  logic                                    cfg_we_i,
  input  logic [mlpfi_pkg::CFG_IW-1:0]            cfg_index_i,
  input  logic [mlpfi_pkg::CFG_DW-1:0]            cfg_data_i
);

  import mlpfi_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers, stored raw and clamped on use
  // ---------------------------------------------------------------------------
  logic [IC_W-1:0] in_cnt_cfg_q;
  logic [HL_W-1:0] hid_cnt_cfg_q;
  logic [NC_W-1:0] node_cnt_cfg_q;
  logic [OC_W-1:0] out_cnt_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_cfg_q   <= IC_W'(1);
      hid_cnt_cfg_q  <= HL_W'(1);
      node_cnt_cfg_q <= NC_W'(1);
      out_cnt_cfg_q  <= OC_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INPUT_COUNT:  in_cnt_cfg_q   <= cfg_data_i[IC_W-1:0];
        CFG_HIDDEN_COUNT: hid_cnt_cfg_q  <= cfg_data_i[HL_W-1:0];
        CFG_NODE_COUNT:   node_cnt_cfg_q <= cfg_data_i[NC_W-1:0];
        CFG_OUTPUT_COUNT: out_cnt_cfg_q  <= cfg_data_i[OC_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero counts run as one, oversized ones as the maximum
  logic [STEP_W-1:0]  nin_c, nnode_c, nout_c;
  logic [LAYER_W-1:0] nlay_c;

  always_comb begin
    nin_c = STEP_W'(in_cnt_cfg_q);
    if (in_cnt_cfg_q == '0) nin_c = STEP_W'(1);
    else if (in_cnt_cfg_q > IC_W'(MAX_INPUTS)) nin_c = STEP_W'(MAX_INPUTS);

    nnode_c = STEP_W'(node_cnt_cfg_q);
    if (node_cnt_cfg_q == '0) nnode_c = STEP_W'(1);
    else if (node_cnt_cfg_q > NC_W'(MAX_NODES)) nnode_c = STEP_W'(MAX_NODES);

    nout_c = STEP_W'(out_cnt_cfg_q);
    if (out_cnt_cfg_q == '0) nout_c = STEP_W'(1);
    else if (out_cnt_cfg_q > OC_W'(MAX_OUTPUTS)) nout_c = STEP_W'(MAX_OUTPUTS);

    nlay_c = LAYER_W'(hid_cnt_cfg_q);
    if (hid_cnt_cfg_q == '0) nlay_c = LAYER_W'(1);
    else if (hid_cnt_cfg_q > HL_W'(MAX_LAYERS)) nlay_c = LAYER_W'(MAX_LAYERS);
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [CNT_W-1:0]   samples_q, samples_d;
  logic [LAYER_W-1:0] layer_q, layer_d;     // 0..nl-1 hidden, nl is the output layer
  logic [NODE_AW-1:0] node_q, node_d;       // destination node in this layer
  logic [STEP_W-1:0]  step_q, step_d;       // source index, nsrc means the bias
  logic [WADDR_W-1:0] base_q, base_d;       // first weight of this layer
  logic [WADDR_W-1:0] addr_q, addr_d;       // weight address being issued

  // MAC pipe: s1 = RAM data out, s2 = product registered
  logic s1_valid_q, s1_valid_d, s1_bias_q, s1_bias_d, s2_valid_q, s2_valid_d;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [DATA_W-1:0] vsat_q, vsat_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_value_q, out_value_d;
  logic [OIDX_W-1:0]        out_index_q, out_index_d;
  logic                     out_last_q, out_last_d;

  // ---------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------
  logic                     in_xfer, weight_we, sample_we;
  logic                     a_we, b_we;
  logic [DATA_W-1:0]        w_rdata, samp_rdata, a_rdata, b_rdata;
  logic signed [DATA_W-1:0] node_res;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign weight_we = in_xfer && (mode_i == MODE_WEIGHT);
  assign sample_we = in_xfer && (mode_i == MODE_SAMPLE);

  mlpfi_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (weight_we),
    .waddr_i (weight_index_i),
    .wdata_i (data_value_i),
    .raddr_i (addr_q),
    .rdata_o (w_rdata)
  );

  mlpfi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_INPUTS)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (sample_we),
    .waddr_i (samples_q[IN_AW-1:0]),
    .wdata_i (data_value_i),
    .raddr_i (step_q[IN_AW-1:0]),
    .rdata_o (samp_rdata)
  );

  mlpfi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_layer_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (node_q),
    .wdata_i (node_res),
    .raddr_i (step_q[NODE_AW-1:0]),
    .rdata_o (a_rdata)
  );

  mlpfi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_layer_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (node_q),
    .wdata_i (node_res),
    .raddr_i (step_q[NODE_AW-1:0]),
    .rdata_o (b_rdata)
  );

  // ---------------------------------------------------------------------------
  // Layer geometry. Layer 0 reads samples and writes A; layer l writes A when
  // l is even and reads what layer l-1 wrote.
  // ---------------------------------------------------------------------------
  logic              is_out_layer, is_bias, last_node;
  logic [STEP_W-1:0] nsrc, ndst;

  assign is_out_layer = (layer_q == nlay_c);
  assign nsrc         = (layer_q == '0) ? nin_c : nnode_c;
  assign ndst         = is_out_layer ? nout_c : nnode_c;
  assign is_bias      = (step_q == nsrc);
  assign last_node    = ((STEP_W'(node_q) + STEP_W'(1)) == ndst);

  // ---------------------------------------------------------------------------
  // Shared multiplier: MAC products (bias scaled by 256) and the leaky slope
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] src_rdata, mul_a, mul_b;

  always_comb begin
    if (layer_q == '0) src_rdata = samp_rdata;
    else if (layer_q[0]) src_rdata = a_rdata;
    else src_rdata = b_rdata;

    if (state_q == ST_LEAK) begin
      mul_a = vsat_q;
      mul_b = DATA_W'(LEAK_MUL);
    end else begin
      mul_a = w_rdata;
      mul_b = s1_bias_q ? DATA_W'(256) : src_rdata;
    end
  end

  // Slope product held in store so a stalled output node keeps its value
  always_ff @(posedge clk_i) begin
    if (state_q != ST_STORE) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Activated node value: negatives take the leaky product, floored
  assign node_res = vsat_q[DATA_W-1] ? prod_q[PROD_W-1:DATA_W] : vsat_q;

  assign a_we = (state_q == ST_STORE) && !is_out_layer && !layer_q[0];
  assign b_we = (state_q == ST_STORE) && !is_out_layer && layer_q[0];

  // ---------------------------------------------------------------------------
  // State register and control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      samples_q   <= '0;
      layer_q     <= '0;
      node_q      <= '0;
      step_q      <= '0;
      base_q      <= '0;
      addr_q      <= '0;
      s1_valid_q  <= 1'b0;
      s1_bias_q   <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      samples_q   <= samples_d;
      layer_q     <= layer_d;
      node_q      <= node_d;
      step_q      <= step_d;
      base_q      <= base_d;
      addr_q      <= addr_d;
      s1_valid_q  <= s1_valid_d;
      s1_bias_q   <= s1_bias_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    vsat_q      <= vsat_d;
    out_value_q <= out_value_d;
    out_index_q <= out_index_d;
    out_last_q  <= out_last_d;
  end

  // ---------------------------------------------------------------------------
  // Next state and outputs
  // ---------------------------------------------------------------------------
  logic [CNT_W:0] samples_inc;

  assign samples_inc = {1'b0, samples_q} + (CNT_W + 1)'(1);

  always_comb begin
    state_d     = state_q;
    samples_d   = samples_q;
    layer_d     = layer_q;
    node_d      = node_q;
    step_d      = step_q;
    base_d      = base_q;
    addr_d      = addr_q;
    s1_valid_d  = 1'b0;
    s1_bias_d   = 1'b0;
    s2_valid_d  = s1_valid_q;
    acc_d       = s2_valid_q ? acc_q + ACC_W'(prod_q) : acc_q;
    vsat_d      = vsat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_index_d = out_index_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (sample_we) begin
          if (samples_inc >= (CNT_W + 1)'(nin_c)) begin
            // vector complete: start layer 0, node 0
            samples_d = '0;
            layer_d   = '0;
            node_d    = '0;
            step_d    = '0;
            base_d    = '0;
            addr_d    = '0;
            acc_d     = '0;
            state_d   = ST_MAC;
          end else begin
            samples_d = samples_inc[CNT_W-1:0];
          end
        end
      end

      ST_MAC: begin
        // one weight read per cycle, bias last
        s1_valid_d = 1'b1;
        s1_bias_d  = is_bias;
        if (is_bias) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + STEP_W'(1);
          addr_d = addr_q + WADDR_W'(ndst);
        end
      end

      ST_DRAIN: begin
        if (!s1_valid_q && !s2_valid_q) begin
          // acc >> 8, saturated to 16 bits
          if (acc_q[ACC_W-1:DATA_W+7] == '0 || acc_q[ACC_W-1:DATA_W+7] == '1) begin
            vsat_d = acc_q[DATA_W+7:8];
          end else if (acc_q[ACC_W-1]) begin
            vsat_d = {1'b1, {(DATA_W-1){1'b0}}};
          end else begin
            vsat_d = {1'b0, {(DATA_W-1){1'b1}}};
          end
          state_d = ST_LEAK;
        end
      end

      ST_LEAK: begin
        state_d = ST_STORE;
      end

      ST_STORE: begin
        if (!is_out_layer || !out_valid_q || out_ready_i) begin
          if (is_out_layer) begin
            out_valid_d = 1'b1;
            out_value_d = node_res;
            out_index_d = OIDX_W'(node_q);
            out_last_d  = last_node;
          end
          step_d = '0;
          acc_d  = '0;
          if (!last_node) begin
            node_d  = node_q + NODE_AW'(1);
            addr_d  = base_q + WADDR_W'(node_q) + WADDR_W'(1);
            state_d = ST_MAC;
          end else if (is_out_layer) begin
            state_d = ST_IDLE;
          end else begin
            // next layer starts right after this layer's last bias
            layer_d = layer_q + LAYER_W'(1);
            node_d  = '0;
            base_d  = addr_q + WADDR_W'(1);
            addr_d  = addr_q + WADDR_W'(1);
            state_d = ST_MAC;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_index_o = out_index_q;
  assign last_o      = out_last_q;

endmodule

FILE: hdl/mlpfi_checker.sv
// Port-level checks for the MLP inference unit, bound to the top level.
module mlpfi_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                mode_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [mlpfi_pkg::DATA_W-1:0] out_value_o,
  input logic [mlpfi_pkg::OIDX_W-1:0]        out_index_o,
  input logic                                last_o
);

  import mlpfi_pkg::*;

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_value_o) && $stable(out_index_o) && $stable(last_o))
    else $error("result changed while stalled");

  // A weight transfer never starts an inference
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_WEIGHT) |=> in_ready_o)
    else $error("busy after weight transfer");

  // Only a sample transfer can make the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && mode_i == MODE_SAMPLE))
    else $error("busy without a sample transfer");

  // While a non-final result waits, the inference is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("ready before the final result");

endmodule

bind mlp_forward_inference_unit mlpfi_checker u_mlpfi_checker (.*);
